[rtl/chm_pkg.sv]
// package for the chained hash map
// types, sizes and codes shared by the rtl files
package chm_pkg;
    localparam int MAX_BUCKETS = 64;
    localparam int SLOTS = 8;
    localparam int TOTAL = MAX_BUCKETS * SLOTS;
    localparam int BW = $clog2(MAX_BUCKETS);
    localparam int SW = $clog2(SLOTS);
    localparam int AW = $clog2(TOTAL);
    localparam int FW = $clog2(SLOTS + 1);
    localparam int KW = 31;
    localparam int VW = 32;
    localparam int CW = 7;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_SEARCH = 2'd2;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef enum logic [3:0] {
        t_IDLE, t_MOD, t_FILL, t_FGET, t_READ, t_CMP, t_SHRD, t_SHWR, t_INS, t_OUT, t_CLR
    } t_state;
endpackage

[rtl/chm_if.sv]
// valid/ready channel interfaces for the chained hash map
// uses chm_pkg for widths
interface chm_req_if;
    logic valid;
    logic ready;
    logic [1:0] req_type;
    logic [chm_pkg::KW-1:0] key;
    logic signed [chm_pkg::VW-1:0] value;
    modport source(output valid, req_type, key, value, input ready);
    modport sink(input valid, req_type, key, value, output ready);
endinterface

interface chm_rsp_if;
    logic valid;
    logic ready;
    logic [1:0] status;
    logic signed [chm_pkg::VW-1:0] result_value;
    modport source(output valid, status, result_value, input ready);
    modport sink(input valid, status, result_value, output ready);
endinterface

interface chm_cfg_if;
    logic valid;
    logic ready;
    logic [chm_pkg::CW-1:0] data;
    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface

[rtl/chm_ram.sv]
// generic single port ram with registered read
// no dependencies
module chm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

[rtl/chained_hash_map.sv]
// chained hash map top level: sequencer, restoring modulo, slot walk
// uses chm_pkg, chm_if interfaces and chm_ram
//
// Requests arrive on i_req (insert, delete, search); one response per
// request leaves on o_rsp. i_cfg writes the bucket count; each write starts
// a pass that clears the per-bucket fill counters held in a ram.
// Each request: the key is reduced modulo the bucket count (0 taken as 1,
// above 64 taken as 64) by a restoring subtract unit, one quotient bit a
// cycle, then the FILL and FGET states read the fill count; insert then
// writes the next free slot if the bucket is not full, while delete and
// search walk the bucket slots, READ and CMP per slot, via the slot ram.
// Delete shifts later slots down, through SHRD and SHWR per moved slot.
// After the response is loaded the sequencer returns to idle, where the
// next request is taken.
// One request is in work at a time; i_req.ready is low meanwhile and while
// i_cfg.valid is high. The response waits in an output register until taken;
// a stalled receiver holds the following request at its end, losing nothing.
// After reset the bucket count is 64 and the clearing pass runs
// before the first request or configuration item is taken.
module chained_hash_map (
    input  logic i_clk,
    input  logic i_rst_n,
    chm_req_if.sink   i_req,
    chm_rsp_if.source o_rsp,
    chm_cfg_if.sink   i_cfg
);
    chm_pkg::t_state r_state, n_state;
    logic [chm_pkg::CW-1:0] r_bc;
    logic [1:0] r_req;
    logic [chm_pkg::KW-1:0] r_key, r_rem_src;
    logic [chm_pkg::VW-1:0] r_val, r_res, r_ores;
    logic [chm_pkg::CW:0] r_rem;
    logic [4:0] r_cnt;
    logic [chm_pkg::BW-1:0] r_b, r_clr;
    logic [chm_pkg::FW-1:0] r_f, r_i;
    logic [1:0] r_st, r_ost;
    logic r_ovalid;

    logic [chm_pkg::CW-1:0] w_div;
    logic [chm_pkg::CW:0] w_sh;
    logic w_we;
    logic [chm_pkg::AW-1:0] w_addr;
    logic [chm_pkg::KW-1:0] w_wkey, w_rkey;
    logic [chm_pkg::VW-1:0] w_wval, w_rval;
    logic w_fwe;
    logic [chm_pkg::BW-1:0] w_faddr;
    logic [chm_pkg::FW-1:0] w_fwdata, w_frd;
    logic w_out_load;

    always_comb begin
        if (r_bc == '0) w_div = chm_pkg::CW'(1);
        else if (r_bc > chm_pkg::CW'(chm_pkg::MAX_BUCKETS))
            w_div = chm_pkg::CW'(chm_pkg::MAX_BUCKETS);
        else w_div = r_bc;
    end

    assign w_sh = {r_rem[chm_pkg::CW-1:0], r_rem_src[chm_pkg::KW-1]};
    assign w_out_load = (r_state == chm_pkg::t_OUT) && (!r_ovalid || o_rsp.ready);
    assign i_req.ready = (r_state == chm_pkg::t_IDLE) && !i_cfg.valid;
    assign i_cfg.ready = (r_state == chm_pkg::t_IDLE);
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.status = r_ost;
    assign o_rsp.result_value = r_ores;

    always_comb begin
        n_state = r_state;
        w_we = 1'b0;
        w_addr = {r_b, r_i[chm_pkg::SW-1:0]};
        w_wkey = r_key;
        w_wval = r_val;
        w_fwe = 1'b0;
        w_faddr = r_b;
        w_fwdata = r_f;
        case (r_state)
            chm_pkg::t_CLR: begin
                w_fwe = 1'b1;
                w_faddr = r_clr;
                w_fwdata = '0;
                if (r_clr == chm_pkg::BW'(chm_pkg::MAX_BUCKETS - 1)) n_state = chm_pkg::t_IDLE;
            end
            chm_pkg::t_IDLE: begin
                if (i_cfg.valid) n_state = chm_pkg::t_CLR;
                else if (i_req.valid && i_req.ready) n_state = chm_pkg::t_MOD;
            end
            chm_pkg::t_MOD: if (r_cnt == 5'd30) n_state = chm_pkg::t_FILL;
            chm_pkg::t_FILL: begin
                w_faddr = r_rem[chm_pkg::BW-1:0];
                n_state = chm_pkg::t_FGET;
            end
            chm_pkg::t_FGET: begin
                if (r_req == chm_pkg::REQ_INSERT) n_state = chm_pkg::t_INS;
                else if (r_req == chm_pkg::REQ_DELETE || r_req == chm_pkg::REQ_SEARCH)
                    n_state = chm_pkg::t_READ;
                else n_state = chm_pkg::t_OUT;
            end
            chm_pkg::t_READ: begin
                if (r_i >= r_f) n_state = chm_pkg::t_OUT;
                else n_state = chm_pkg::t_CMP;
            end
            chm_pkg::t_CMP: begin
                if (w_rkey == r_key) begin
                    if (r_req == chm_pkg::REQ_DELETE) n_state = chm_pkg::t_SHRD;
                    else n_state = chm_pkg::t_OUT;
                end else n_state = chm_pkg::t_READ;
            end
            chm_pkg::t_SHRD: begin
                w_addr = {r_b, chm_pkg::SW'(r_i + 1'b1)};
                if (r_i + 1'b1 >= r_f) begin
                    n_state = chm_pkg::t_OUT;
                    w_fwe = 1'b1;
                    w_fwdata = r_f - 1'b1;
                end else n_state = chm_pkg::t_SHWR;
            end
            chm_pkg::t_SHWR: begin
                w_we = 1'b1;
                w_wkey = w_rkey;
                w_wval = w_rval;
                n_state = chm_pkg::t_SHRD;
            end
            chm_pkg::t_INS: begin
                w_addr = {r_b, r_f[chm_pkg::SW-1:0]};
                w_we = (r_f < chm_pkg::FW'(chm_pkg::SLOTS));
                w_fwe = (r_f < chm_pkg::FW'(chm_pkg::SLOTS));
                w_fwdata = r_f + 1'b1;
                n_state = chm_pkg::t_OUT;
            end
            chm_pkg::t_OUT: if (w_out_load) n_state = chm_pkg::t_IDLE;
            default: n_state = chm_pkg::t_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= chm_pkg::t_CLR;
            r_bc <= chm_pkg::CW'(chm_pkg::MAX_BUCKETS);
            r_ovalid <= 1'b0;
            r_clr <= '0;
        end else begin
            r_state <= n_state;
            if (w_out_load) r_ovalid <= 1'b1;
            else if (o_rsp.valid && o_rsp.ready) r_ovalid <= 1'b0;
            if (i_cfg.valid && i_cfg.ready) r_bc <= i_cfg.data;
            if (r_state == chm_pkg::t_CLR) r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_ost <= r_st;
            r_ores <= r_res;
        end
        case (r_state)
            chm_pkg::t_IDLE: begin
                r_req <= i_req.req_type;
                r_key <= i_req.key;
                r_rem_src <= i_req.key;
                r_val <= i_req.value;
                r_rem <= '0;
                r_cnt <= '0;
                r_i <= '0;
                r_st <= chm_pkg::ST_MISS;
                r_res <= '0;
            end
            chm_pkg::t_MOD: begin
                r_cnt <= r_cnt + 1'b1;
                r_rem_src <= {r_rem_src[chm_pkg::KW-2:0], 1'b0};
                if (w_sh >= {1'b0, w_div}) r_rem <= w_sh - {1'b0, w_div};
                else r_rem <= w_sh;
            end
            chm_pkg::t_FILL: r_b <= r_rem[chm_pkg::BW-1:0];
            chm_pkg::t_FGET: begin
                if (w_frd > chm_pkg::FW'(chm_pkg::SLOTS)) r_f <= chm_pkg::FW'(chm_pkg::SLOTS);
                else r_f <= w_frd;
            end
            chm_pkg::t_CMP: begin
                if (w_rkey == r_key) begin
                    r_st <= chm_pkg::ST_DONE;
                    r_res <= w_rval;
                end else r_i <= r_i + 1'b1;
            end
            chm_pkg::t_SHWR: r_i <= r_i + 1'b1;
            chm_pkg::t_INS: begin
                if (r_f < chm_pkg::FW'(chm_pkg::SLOTS)) r_st <= chm_pkg::ST_DONE;
                else r_st <= chm_pkg::ST_FULL;
            end
            default: ;
        endcase
    end

    chm_ram #(.WIDTH(chm_pkg::KW), .DEPTH(chm_pkg::TOTAL)) u_keys (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr), .i_wdata(w_wkey), .o_rdata(w_rkey)
    );
    chm_ram #(.WIDTH(chm_pkg::VW), .DEPTH(chm_pkg::TOTAL)) u_vals (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr), .i_wdata(w_wval), .o_rdata(w_rval)
    );
    chm_ram #(.WIDTH(chm_pkg::FW), .DEPTH(chm_pkg::MAX_BUCKETS)) u_fill (
        .i_clk(i_clk), .i_we(w_fwe), .i_addr(w_faddr), .i_wdata(w_fwdata), .o_rdata(w_frd)
    );
endmodule
